/* rtl/nlc_pkg.sv */
`timescale 1ns / 1ps
// shared types, codes and reset values of the notification led compositor
// no dependencies

package nlc_pkg;

    localparam int COLOR_W = 24;
    localparam int TIME_W  = 16;
    localparam int FM_W    = 2;
    localparam int SRC_W   = 2;
    localparam int DEB_W   = 8;
    localparam int NUM_SRC = 3;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 32;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    // item kinds
    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // sources
    localparam logic [SRC_W-1:0] SRC_BATTERY      = 2'd0;
    localparam logic [SRC_W-1:0] SRC_NOTIFICATION = 2'd1;
    localparam logic [SRC_W-1:0] SRC_ATTENTION    = 2'd2;
    localparam logic [SRC_W-1:0] SRC_INVALID      = 2'd3;

    // flash modes
    localparam logic [FM_W-1:0] FM_NONE     = 2'd0;
    localparam logic [FM_W-1:0] FM_TIMED    = 2'd1;
    localparam logic [FM_W-1:0] FM_HARDWARE = 2'd2;

    // register indexes
    localparam logic [1:0] REG_DEBOUNCE      = 2'd0;
    localparam logic [1:0] REG_MIN_FLASH     = 2'd1;
    localparam logic [1:0] REG_DEFAULT_FLASH = 2'd2;

    localparam logic [DEB_W-1:0]  DEBOUNCE_RESET      = 8'd50;
    localparam logic [TIME_W-1:0] MIN_FLASH_RESET     = 16'd50;
    localparam logic [TIME_W-1:0] DEFAULT_FLASH_RESET = 16'd1000;
    localparam logic [DEB_W-1:0]  SINCE_MAX           = 8'hFF;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [FM_W-1:0]    flash_mode;
        logic [TIME_W-1:0]  on_time;
        logic [TIME_W-1:0]  off_time;
    } led_req_t;

    localparam led_req_t REQ_OFF = '0;

endpackage

/* rtl/notification_led_compositor_core.sv */
`timescale 1ns / 1ps
// notification led compositor: source records, debounce, priority pick and blink timer
// depends on nlc_pkg
//
// usage:
//   s_ channel carries one beat per item: a one millisecond tick (tuser = 0)
//   or a source request write (tuser = 1) with source, color, flash mode and
//   on and off times in tdata.
//   m_ channel returns one beat per item with the led color, the blink flag
//   and whether a write was applied, all after the item took effect.
//   apb port holds debounce_ms (0x0), min_flash_ms (0x4), default_flash_ms (0x8);
//   write them only while no beat is in flight.
// path: an accepted s_ beat goes through the input register, then the update logic
//   into the result register, before its m_ beat.
// throughput: one item per cycle with m_tready high; one update stage owns all state.
// reset: aresetn low clears all records to off, blinking off, color zero,
//   the time since the last apply to its saturated value and the registers
//   to 50, 50 and 1000 ms.
// stall: with m_tready low the result register holds and the input register
//   takes one more beat, then s_tready drops until the result is taken.

module notification_led_compositor_core (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_tvalid,
    output logic                          s_tready,
    // source[1:0], color[25:2], flash_mode[27:26], on_time[43:28],
    // off_time[59:44], zero[63:60]
    input  logic [nlc_pkg::S_TDATA_W-1:0] s_tdata,
    // mode[0]
    input  logic                          s_tuser,

    output logic                          m_tvalid,
    input  logic                          m_tready,
    // led_color[23:0], blink_active[24], write_applied[25], zero[31:26]
    output logic [nlc_pkg::M_TDATA_W-1:0] m_tdata,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nlc_pkg::PADDR_W-1:0]   paddr,
    input  logic [nlc_pkg::PDATA_W-1:0]   pwdata,
    output logic [nlc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int CW = nlc_pkg::COLOR_W;
    localparam int TW = nlc_pkg::TIME_W;

    // config registers
    logic [nlc_pkg::DEB_W-1:0] debounce_reg;
    logic [TW-1:0]             min_flash_reg;
    logic [TW-1:0]             default_flash_reg;
    logic                      cfg_wr;

    // input register
    logic                      in_valid_reg;
    logic                      in_mode_reg;
    logic [nlc_pkg::SRC_W-1:0] in_src_reg;
    nlc_pkg::led_req_t         in_req_reg;

    // state
    nlc_pkg::led_req_t         rec_reg [nlc_pkg::NUM_SRC];
    nlc_pkg::led_req_t         rec_next [nlc_pkg::NUM_SRC];
    logic [nlc_pkg::DEB_W-1:0] since_reg, since_next;
    logic                      blink_en_reg, blink_en_next;
    logic [CW-1:0]             blink_color_reg, blink_color_next;
    logic [TW-1:0]             blink_on_reg, blink_on_next;
    logic [TW-1:0]             blink_off_reg, blink_off_next;
    logic                      phase_on_reg, phase_on_next;
    logic [TW-1:0]             timer_reg, timer_next;
    logic [CW-1:0]             static_reg, static_next;

    // result register
    logic                      out_valid_reg;
    logic [CW-1:0]             out_color_reg, out_color_next;
    logic                      out_blink_reg;
    logic                      out_applied_reg, out_applied_next;

    logic                      fire;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(nlc_pkg::M_TDATA_W - CW - 2){1'b0}},
                       out_applied_reg, out_blink_reg, out_color_reg};

    // apb
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        case (paddr[3:2])
            nlc_pkg::REG_DEBOUNCE:      prdata[nlc_pkg::DEB_W-1:0] = debounce_reg;
            nlc_pkg::REG_MIN_FLASH:     prdata[TW-1:0] = min_flash_reg;
            nlc_pkg::REG_DEFAULT_FLASH: prdata[TW-1:0] = default_flash_reg;
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg      <= nlc_pkg::DEBOUNCE_RESET;
            min_flash_reg     <= nlc_pkg::MIN_FLASH_RESET;
            default_flash_reg <= nlc_pkg::DEFAULT_FLASH_RESET;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                nlc_pkg::REG_DEBOUNCE:      debounce_reg <= pwdata[nlc_pkg::DEB_W-1:0];
                nlc_pkg::REG_MIN_FLASH:     min_flash_reg <= pwdata[TW-1:0];
                nlc_pkg::REG_DEFAULT_FLASH: default_flash_reg <= pwdata[TW-1:0];
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_mode_reg         <= s_tuser;
            in_src_reg          <= s_tdata[1:0];
            in_req_reg.color    <= s_tdata[25:2];
            in_req_reg.flash_mode <= s_tdata[27:26];
            in_req_reg.on_time  <= s_tdata[43:28];
            in_req_reg.off_time <= s_tdata[59:44];
        end
    end

    // update stage
    always_comb begin
        logic              is_write;
        logic              all_off;
        logic              apply;
        nlc_pkg::led_req_t pick;
        logic              want;
        logic [TW-1:0]     on_t;
        logic [TW-1:0]     off_t;
        logic              changed;

        for (int i = 0; i < nlc_pkg::NUM_SRC; i++) begin
            rec_next[i] = rec_reg[i];
        end
        since_next       = since_reg;
        blink_en_next    = blink_en_reg;
        blink_color_next = blink_color_reg;
        blink_on_next    = blink_on_reg;
        blink_off_next   = blink_off_reg;
        phase_on_next    = phase_on_reg;
        timer_next       = timer_reg;
        static_next      = static_reg;
        apply            = 1'b0;
        pick             = nlc_pkg::REQ_OFF;
        want             = 1'b0;
        on_t             = '0;
        off_t            = '0;
        changed          = 1'b0;
        all_off          = 1'b0;

        is_write = (in_mode_reg == nlc_pkg::MODE_WRITE);

        if (!is_write) begin
            if (since_reg != nlc_pkg::SINCE_MAX) begin
                since_next = since_reg + 1'b1;
            end
            if (blink_en_reg) begin
                if (timer_reg <= TW'(1)) begin
                    phase_on_next = !phase_on_reg;
                    timer_next    = phase_on_reg ? blink_off_reg : blink_on_reg;
                end else begin
                    timer_next = timer_reg - 1'b1;
                end
            end
        end else if (in_src_reg != nlc_pkg::SRC_INVALID) begin
            case (in_src_reg)
                nlc_pkg::SRC_BATTERY:      rec_next[0] = in_req_reg;
                nlc_pkg::SRC_NOTIFICATION: rec_next[1] = in_req_reg;
                nlc_pkg::SRC_ATTENTION:    rec_next[2] = in_req_reg;
                default: ;
            endcase
            all_off = (rec_next[0].color == '0) && (rec_next[1].color == '0) &&
                      (rec_next[2].color == '0);
            apply = all_off || (since_reg >= debounce_reg);
            if (apply) begin
                since_next = '0;
                if (rec_next[1].color != '0) begin
                    pick = rec_next[1];
                end else if (rec_next[2].color != '0) begin
                    pick = rec_next[2];
                end else if (rec_next[0].color != '0) begin
                    pick = rec_next[0];
                end
                want = ((pick.flash_mode == nlc_pkg::FM_TIMED) ||
                        (pick.flash_mode == nlc_pkg::FM_HARDWARE)) &&
                       (pick.color != '0);
                on_t  = pick.on_time;
                off_t = pick.off_time;
                if (want) begin
                    if (on_t < min_flash_reg) on_t = default_flash_reg;
                    if (off_t < min_flash_reg) off_t = default_flash_reg;
                    changed = !blink_en_reg || (pick.color != blink_color_reg) ||
                              (on_t != blink_on_reg) || (off_t != blink_off_reg);
                    if (changed) begin
                        phase_on_next = 1'b1;
                        timer_next    = on_t;
                    end
                end else begin
                    static_next   = pick.color;
                    phase_on_next = 1'b0;
                    timer_next    = '0;
                end
                blink_en_next    = want;
                blink_color_next = pick.color;
                blink_on_next    = on_t;
                blink_off_next   = off_t;
            end
        end

        out_applied_next = apply;
        out_color_next   = blink_en_next ? (phase_on_next ? blink_color_next : '0)
                                         : static_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < nlc_pkg::NUM_SRC; i++) begin
                rec_reg[i] <= nlc_pkg::REQ_OFF;
            end
            since_reg       <= nlc_pkg::SINCE_MAX;
            blink_en_reg    <= 1'b0;
            blink_color_reg <= '0;
            blink_on_reg    <= '0;
            blink_off_reg   <= '0;
            phase_on_reg    <= 1'b0;
            timer_reg       <= '0;
            static_reg      <= '0;
        end else if (fire) begin
            for (int i = 0; i < nlc_pkg::NUM_SRC; i++) begin
                rec_reg[i] <= rec_next[i];
            end
            since_reg       <= since_next;
            blink_en_reg    <= blink_en_next;
            blink_color_reg <= blink_color_next;
            blink_on_reg    <= blink_on_next;
            blink_off_reg   <= blink_off_next;
            phase_on_reg    <= phase_on_next;
            timer_reg       <= timer_next;
            static_reg      <= static_next;
        end
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_color_reg   <= out_color_next;
            out_blink_reg   <= blink_en_next;
            out_applied_reg <= out_applied_next;
        end
    end

endmodule

/* bench/notification_led_compositor_core_tb.sv */
`timescale 1ns / 1ps
// self-checking bench for notification_led_compositor_core: directed table, then random phases
// with varied register settings and stream idling; depends on nlc_pkg and the core rtl

module notification_led_compositor_core_tb;
    import nlc_pkg::*;

    localparam int          PLAN_LEN    = 27;
    localparam int          NUM_PHASES  = 8;
    localparam int          PHASE_BEATS = 100;
    localparam int          LONG_HOLD   = 400;
    localparam int          CYCLE_LIMIT = 200000;
    localparam logic        ROW_ITEM    = 1'b0;
    localparam logic        ROW_CFG     = 1'b1;
    localparam logic [FM_W-1:0] FM_UNKNOWN = 2'd3;

    typedef struct packed {
        logic               mode;
        logic [SRC_W-1:0]   source;
        logic [COLOR_W-1:0] color;
        logic [FM_W-1:0]    flash_mode;
        logic [TIME_W-1:0]  on_time;
        logic [TIME_W-1:0]  off_time;
    } led_item_t;

    typedef struct packed {
        logic [COLOR_W-1:0] led_color;
        logic               blink_active;
        logic               write_applied;
    } led_out_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  reg_idx;
        logic [31:0] value;
        led_item_t   beat_in;
        logic        typed;
        led_out_t    want;
    } plan_row_t;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [PADDR_W-1:0]    paddr    = '0;
    logic [PDATA_W-1:0]    pwdata   = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    notification_led_compositor_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // predictor state
    logic [DEB_W-1:0]   cfg_debounce      = DEBOUNCE_RESET;
    logic [TIME_W-1:0]  cfg_min_flash     = MIN_FLASH_RESET;
    logic [TIME_W-1:0]  cfg_default_flash = DEFAULT_FLASH_RESET;
    led_req_t           rec [NUM_SRC]     = '{default: REQ_OFF};
    logic [DEB_W-1:0]   ms_since_apply    = SINCE_MAX;
    logic               blink_on_flag     = 1'b0;
    logic [COLOR_W-1:0] blink_rgb         = '0;
    logic [TIME_W-1:0]  blink_on_ms       = '0;
    logic [TIME_W-1:0]  blink_off_ms      = '0;
    logic               lit_phase         = 1'b0;
    logic [TIME_W-1:0]  phase_left        = '0;
    logic [COLOR_W-1:0] steady_rgb        = '0;

    led_out_t    led_out_q [$];
    int unsigned mismatches     = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_pending   = 1'b0;
    logic        hold_taken     = 1'b0;
    int unsigned hold_left      = 0;

    plan_row_t plan [0:PLAN_LEN-1] = '{
        '{ROW_ITEM, REG_DEBOUNCE, 32'd0,
          '{MODE_TICK, SRC_BATTERY, 24'h000000, FM_NONE, 16'd0, 16'd0},
          1'b1, '{24'h000000, 1'b0, 1'b0}},
        '{ROW_ITEM, REG_DEBOUNCE, 32'd0,
          '{MODE_WRITE, SRC_BATTERY, 24'hFFFFFF, FM_NONE, 16'd0, 16'd0},
          1'b1, '{24'hFFFFFF, 1'b0, 1'b1}},
        '{ROW_ITEM, REG_DEBOUNCE, 32'd0,
          '{MODE_WRITE, SRC_NOTIFICATION, 24'h000001, FM_TIMED, 16'd0, 16'd0},
          1'b1, '{24'hFFFFFF, 1'b0, 1'b0}},
        '{ROW_ITEM, REG_DEBOUNCE, 32'd0,
          '{MODE_WRITE, SRC_INVALID, 24'h123456, FM_TIMED, 16'hFFFF, 16'hFFFF},
          1'b1, '{24'hFFFFFF, 1'b0, 1'b0}},
        '{ROW_ITEM, REG_DEBOUNCE, 32'd0,
          '{MODE_WRITE, SRC_NOTIFICATION, 24'h000000, FM_NONE, 16'd0, 16'd0},
          1'b1, '{24'hFFFFFF, 1'b0, 1'b0}},
        '{ROW_ITEM, REG_DEBOUNCE, 32'd0,
          '{MODE_WRITE, SRC_BATTERY, 24'h000000, FM_UNKNOWN, 16'd0, 16'd0},
          1'b1, '{24'h000000, 1'b0, 1'b1}},
        '{ROW_CFG, REG_DEBOUNCE, 32'd0, '0, 1'b0, '0},
        '{ROW_CFG, REG_MIN_FLASH, 32'd10, '0, 1'b0, '0},
        '{ROW_CFG, REG_DEFAULT_FLASH, 32'd3, '0, 1'b0, '0},
        '{ROW_ITEM, REG_DEBOUNCE, 32'd0,
          '{MODE_WRITE, SRC_ATTENTION, 24'h00FF00, FM_TIMED, 16'd2, 16'd0},
          1'b0, '0},
        '{ROW_ITEM, REG_DEBOUNCE, 32'd0, '{MODE_TICK, SRC_BATTERY, '0, FM_NONE, '0, '0},
          1'b0, '0},
        '{ROW_ITEM, REG_DEBOUNCE, 32'd0, '{MODE_TICK, SRC_BATTERY, '0, FM_NONE, '0, '0},
          1'b0, '0},
        '{ROW_ITEM, REG_DEBOUNCE, 32'd0, '{MODE_TICK, SRC_BATTERY, '0, FM_NONE, '0, '0},
          1'b0, '0},
        '{ROW_ITEM, REG_DEBOUNCE, 32'd0,
          '{MODE_WRITE, SRC_NOTIFICATION, 24'hFF0000, FM_HARDWARE, 16'hFFFF, 16'hFFFF},
          1'b0, '0},
        '{ROW_ITEM, REG_DEBOUNCE, 32'd0, '{MODE_TICK, SRC_BATTERY, '0, FM_NONE, '0, '0},
          1'b0, '0},
        '{ROW_ITEM, REG_DEBOUNCE, 32'd0,
          '{MODE_WRITE, SRC_NOTIFICATION, 24'hFF0000, FM_HARDWARE, 16'hFFFF, 16'hFFFF},
          1'b0, '0},
        '{ROW_ITEM, REG_DEBOUNCE, 32'd0,
          '{MODE_WRITE, SRC_NOTIFICATION, 24'hFF0000, FM_UNKNOWN, 16'hFFFF, 16'hFFFF},
          1'b1, '{24'hFF0000, 1'b0, 1'b1}},
        '{ROW_ITEM, REG_DEBOUNCE, 32'd0,
          '{MODE_WRITE, SRC_BATTERY, 24'h0000FF, FM_TIMED, 16'd1, 16'd1},
          1'b1, '{24'hFF0000, 1'b0, 1'b1}},
        '{ROW_CFG, REG_MIN_FLASH, 32'd0, '0, 1'b0, '0},
        '{ROW_CFG, REG_DEFAULT_FLASH, 32'd65535, '0, 1'b0, '0},
        '{ROW_ITEM, REG_DEBOUNCE, 32'd0,
          '{MODE_WRITE, SRC_NOTIFICATION, 24'h000000, FM_NONE, 16'd0, 16'd0},
          1'b0, '0},
        '{ROW_ITEM, REG_DEBOUNCE, 32'd0, '{MODE_TICK, SRC_BATTERY, '0, FM_NONE, '0, '0},
          1'b0, '0},
        '{ROW_ITEM, REG_DEBOUNCE, 32'd0, '{MODE_TICK, SRC_BATTERY, '0, FM_NONE, '0, '0},
          1'b0, '0},
        '{ROW_ITEM, REG_DEBOUNCE, 32'd0, '{MODE_TICK, SRC_BATTERY, '0, FM_NONE, '0, '0},
          1'b0, '0},
        '{ROW_CFG, REG_DEBOUNCE, 32'd255, '0, 1'b0, '0},
        '{ROW_ITEM, REG_DEBOUNCE, 32'd0,
          '{MODE_WRITE, SRC_ATTENTION, 24'hFFFFFF, FM_TIMED, 16'd5, 16'd5},
          1'b0, '0},
        '{ROW_ITEM, REG_DEBOUNCE, 32'd0, '{MODE_TICK, SRC_BATTERY, '0, FM_NONE, '0, '0},
          1'b0, '0}
    };

    // per phase: debounce, min flash, default flash, sender idle, receiver stall
    int unsigned ph_debounce [NUM_PHASES] = '{0, 2, 5, 255, 1, 0, 0, 0};
    int unsigned ph_min      [NUM_PHASES] = '{3, 0, 65535, 4, 2, 0, 0, 1};
    int unsigned ph_default  [NUM_PHASES] = '{2, 1, 1, 65535, 3, 1, 1, 4};
    logic        ph_random   [NUM_PHASES] = '{0, 0, 0, 0, 0, 1, 1, 0};
    int unsigned ph_send     [NUM_PHASES] = '{0, 86, 0, 38, 0, 86, 0, 38};
    int unsigned ph_recv     [NUM_PHASES] = '{0, 0, 86, 38, 0, 0, 86, 38};

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic led_out_t compose_led(led_item_t beat);
        led_out_t           res;
        led_req_t           chosen;
        logic               all_dark;
        logic               blinking;
        logic [TIME_W-1:0]  on_ms;
        logic [TIME_W-1:0]  off_ms;
        res.write_applied = 1'b0;
        if (beat.mode == MODE_TICK) begin
            if (ms_since_apply != SINCE_MAX) ms_since_apply++;
            if (blink_on_flag) begin
                if (phase_left <= 1) begin
                    lit_phase  = !lit_phase;
                    phase_left = lit_phase ? blink_on_ms : blink_off_ms;
                end else begin
                    phase_left--;
                end
            end
        end else if (beat.source != SRC_INVALID) begin
            rec[beat.source] = '{beat.color, beat.flash_mode, beat.on_time, beat.off_time};
            all_dark = rec[SRC_BATTERY].color == '0 && rec[SRC_NOTIFICATION].color == '0
                       && rec[SRC_ATTENTION].color == '0;
            if (all_dark || ms_since_apply >= cfg_debounce) begin
                ms_since_apply    = '0;
                res.write_applied = 1'b1;
                if (rec[SRC_NOTIFICATION].color != '0) chosen = rec[SRC_NOTIFICATION];
                else if (rec[SRC_ATTENTION].color != '0) chosen = rec[SRC_ATTENTION];
                else if (rec[SRC_BATTERY].color != '0) chosen = rec[SRC_BATTERY];
                else chosen = REQ_OFF;
                blinking = (chosen.flash_mode == FM_TIMED || chosen.flash_mode == FM_HARDWARE)
                           && chosen.color != '0;
                on_ms  = chosen.on_time;
                off_ms = chosen.off_time;
                if (blinking) begin
                    if (on_ms < cfg_min_flash) on_ms = cfg_default_flash;
                    if (off_ms < cfg_min_flash) off_ms = cfg_default_flash;
                    if (!blink_on_flag || chosen.color != blink_rgb || on_ms != blink_on_ms
                        || off_ms != blink_off_ms) begin
                        lit_phase  = 1'b1;
                        phase_left = on_ms;
                    end
                end else begin
                    steady_rgb = chosen.color;
                    lit_phase  = 1'b0;
                    phase_left = '0;
                end
                blink_on_flag = blinking;
                blink_rgb     = chosen.color;
                blink_on_ms   = on_ms;
                blink_off_ms  = off_ms;
            end
        end
        res.led_color    = blink_on_flag ? (lit_phase ? blink_rgb : '0) : steady_rgb;
        res.blink_active = blink_on_flag;
        return res;
    endfunction

    function automatic led_item_t random_item();
        led_item_t   it;
        int unsigned pick;
        it.mode   = ($urandom_range(99) < 55) ? MODE_TICK : MODE_WRITE;
        it.source = ($urandom_range(99) < 5) ? SRC_INVALID : SRC_W'($urandom_range(2));
        pick = $urandom_range(99);
        if (pick < 20) begin
            it.color = '0;
        end else if (pick < 25) begin
            it.color = 24'hFFFFFF;
        end else if (pick < 45) begin
            case ($urandom_range(2))
                0: it.color = 24'hFF0000;
                1: it.color = 24'h00FF00;
                default: it.color = 24'h0000FF;
            endcase
        end else begin
            it.color = COLOR_W'($urandom);
        end
        it.flash_mode = FM_W'($urandom_range(3));
        it.on_time  = ($urandom_range(99) < 85) ? TIME_W'($urandom_range(6)) : TIME_W'($urandom);
        it.off_time = ($urandom_range(99) < 85) ? TIME_W'($urandom_range(6)) : TIME_W'($urandom);
        return it;
    endfunction

    task automatic offer_item(input led_item_t it, input logic typed, input led_out_t want);
        led_out_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.mode;
        s_tdata  <= {4'b0, it.off_time, it.on_time, it.flash_mode, it.color, it.source};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = compose_led(it);
        if (typed) predicted = want;
        led_out_q = {led_out_q, predicted};
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] val);
        logic [31:0] readback;
        logic [31:0] stored;
        s_tvalid <= 1'b0;
        while (led_out_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_DEBOUNCE: begin
                cfg_debounce = val[DEB_W-1:0];
                stored = 32'(cfg_debounce);
            end
            REG_MIN_FLASH: begin
                cfg_min_flash = val[TIME_W-1:0];
                stored = 32'(cfg_min_flash);
            end
            default: begin
                cfg_default_flash = val[TIME_W-1:0];
                stored = 32'(cfg_default_flash);
            end
        endcase
        if (readback != stored) report_mismatch("register readback", readback, stored);
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", led_out_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    // result side: check each beat, then decide m_tready for the next edge
    always @(posedge aclk) begin : result_side
        led_out_t awaited;
        if (aresetn && m_tvalid && m_tready) begin
            if (led_out_q.size() == 0) begin
                report_mismatch("result beat with nothing pending", m_tdata, '0);
            end else begin
                awaited = led_out_q.pop_front();
                if (m_tdata[23:0] != awaited.led_color)
                    report_mismatch("led_color", m_tdata[23:0], awaited.led_color);
                if (m_tdata[24] != awaited.blink_active)
                    report_mismatch("blink_active", m_tdata[24], awaited.blink_active);
                if (m_tdata[25] != awaited.write_applied)
                    report_mismatch("write_applied", m_tdata[25], awaited.write_applied);
            end
        end
        if (hold_pending && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= LONG_HOLD;
            m_tready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin : stimulus
        int unsigned deb;
        int unsigned min_ms;
        int unsigned dflt_ms;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < PLAN_LEN; i++) begin
            if (plan[i].kind == ROW_CFG) write_register(plan[i].reg_idx, plan[i].value);
            else offer_item(plan[i].beat_in, plan[i].typed, plan[i].want);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            deb     = ph_debounce[ph];
            min_ms  = ph_min[ph];
            dflt_ms = ph_default[ph];
            if (ph_random[ph]) begin
                deb     = $urandom_range(12);
                min_ms  = $urandom_range(8);
                dflt_ms = $urandom_range(8, 1);
            end
            write_register(REG_DEBOUNCE, deb);
            write_register(REG_MIN_FLASH, min_ms);
            write_register(REG_DEFAULT_FLASH, dflt_ms);
            send_idle_pct  = ph_send[ph];
            recv_stall_pct = ph_recv[ph];
            // long receiver hold-off while beats keep coming, so the core backs up
            if (ph == 4) hold_pending <= 1'b1;
            for (int n = 0; n < PHASE_BEATS; n++) offer_item(random_item(), 1'b0, '0);
        end

        s_tvalid <= 1'b0;
        while (led_out_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/nlc_pkg.sv
rtl/notification_led_compositor_core.sv
bench/notification_led_compositor_core_tb.sv
